/* rtl/sacfl_pkg.sv */
package sacfl_pkg;

    // Fixed field widths of the lookup interface.
    localparam int ADDR_W = 32;
    localparam int SLOT_W = 4;
    localparam int LG_W   = 3;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register word indexes on the configuration port.
    localparam logic REG_SET_COUNT_LOG2 = 1'b0;

    // Default number of cache entries.
    localparam int DEF_CACHE_ENTRIES = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEARCH
    } t_state;

    // Status bits that travel with the probing item along the cell chain.
    typedef struct packed {
        logic active;
        logic hit;
        logic free;
    } t_probe_flags;

endpackage

/* rtl/set_assoc_cache_fifo_lookup.sv */
// An accepted item is captured in r_addr, its set bounds go into the launch registers in the
// prepare state, and it walks the cell chain one cell per cycle into the output register. The
// next item is taken once the previous one has left the chain and the pending slot is empty.
// Reset (i_rst_n low at a rising edge, synchronous) invalidates every entry, clears every
// FIFO pointer, sets set_count_log2 to zero and empties the output register.
// A write of set_count_log2 flushes the cache the same way at the write edge.
module set_assoc_cache_fifo_lookup import sacfl_pkg::*; #(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Lookup request channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ADDR_W-1:0]     i_block_address,
    // Lookup result channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_miss,
    output logic [SLOT_W-1:0]     o_slot,
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
    localparam int PROD_W = IDX_W + CNT_W;
    // Largest set_count_log2 that still leaves at least one way per set.
    localparam int MAX_LG = $clog2(CACHE_ENTRIES + 1) - 1;
    localparam int LG_TOP = (1 << LG_W) - 1;
    localparam int LG_CAP = (MAX_LG < LG_TOP) ? MAX_LG : LG_TOP;

    // ------------------------------------------------------------------
    // Configuration register. A write changes the set layout, so every
    // cell drops its entry and its FIFO pointer on the same edge.
    // ------------------------------------------------------------------
    logic [LG_W-1:0] r_lg;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SET_COUNT_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg <= '0;
        end else if (cfg_wr) begin
            r_lg <= pwdata[LG_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_SET_COUNT_LOG2) begin
            prdata = APB_DATA_W'(r_lg);
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Set geometry. The effective log2 saturates so that the set count
    // never exceeds the entry count; the way count is the entry count
    // shifted down, and the leftover entries of a non power of two size
    // simply never fall inside any set.
    // ------------------------------------------------------------------
    logic [LG_W-1:0]   eff_lg;
    logic [CNT_W-1:0]  ways;

    assign eff_lg = (r_lg > LG_W'(LG_CAP)) ? LG_W'(LG_CAP) : r_lg;
    assign ways   = CNT_W'(CACHE_ENTRIES) >> eff_lg;

    // ------------------------------------------------------------------
    // Control. An item is captured in r_addr, its set bounds are worked
    // out in the prepare cycle, and then it is launched into cell 0.
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [ADDR_W-1:0] r_addr;
    logic              r_pend_valid;
    logic              in_take;
    logic              tail_done;

    assign o_stall = (r_state != ST_IDLE) || r_pend_valid;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (tail_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_addr <= i_block_address;
        end
    end

    // Launch registers feeding the head of the chain.
    logic [IDX_W-1:0]  set_sel;
    logic [PROD_W-1:0] base_prod;
    logic [CNT_W-1:0]  base_calc;

    logic              r_l_active;
    logic [CNT_W-1:0]  r_l_base;
    logic [CNT_W-1:0]  r_l_limit;
    logic [IDX_W-1:0]  r_l_set;

    assign set_sel   = r_addr[IDX_W-1:0] & ~({IDX_W{1'b1}} << eff_lg);
    assign base_prod = PROD_W'(set_sel) * PROD_W'(ways);
    assign base_calc = base_prod[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_active <= 1'b0;
        end else begin
            r_l_active <= (r_state == ST_PREP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_l_base  <= base_calc;
        r_l_limit <= base_calc + ways;
        r_l_set   <= set_sel;
    end

    // ------------------------------------------------------------------
    // Cell chain. Each cell owns one entry (tag, valid bit) and the FIFO
    // pointer of the set whose number equals its index. The item moves one
    // cell per cycle and collects the first hit, the first free way of its
    // set and its set's FIFO pointer.
    // ------------------------------------------------------------------
    t_probe_flags      lk_flags   [0:CACHE_ENTRIES];
    logic [ADDR_W-1:0] lk_addr    [0:CACHE_ENTRIES];
    logic [CNT_W-1:0]  lk_base    [0:CACHE_ENTRIES];
    logic [CNT_W-1:0]  lk_limit   [0:CACHE_ENTRIES];
    logic [IDX_W-1:0]  lk_set     [0:CACHE_ENTRIES];
    logic [IDX_W-1:0]  lk_hit_idx [0:CACHE_ENTRIES];
    logic [IDX_W-1:0]  lk_free_idx[0:CACHE_ENTRIES];
    logic [IDX_W-1:0]  lk_ptr     [0:CACHE_ENTRIES];

    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              ptr_wr_en;
    logic [IDX_W-1:0]  ptr_wr_val;

    assign lk_flags[0]    = '{active: r_l_active, hit: 1'b0, free: 1'b0};
    assign lk_addr[0]     = r_addr;
    assign lk_base[0]     = r_l_base;
    assign lk_limit[0]    = r_l_limit;
    assign lk_set[0]      = r_l_set;
    assign lk_hit_idx[0]  = '0;
    assign lk_free_idx[0] = '0;
    assign lk_ptr[0]      = '0;

    for (genvar gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cell
        sacfl_cell #(
            .CACHE_ENTRIES (CACHE_ENTRIES),
            .CELL_INDEX    (gi),
            .IDX_W         (IDX_W),
            .CNT_W         (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_flush      (cfg_wr),
            .i_flags      (lk_flags[gi]),
            .i_addr       (lk_addr[gi]),
            .i_base       (lk_base[gi]),
            .i_limit      (lk_limit[gi]),
            .i_set        (lk_set[gi]),
            .i_hit_idx    (lk_hit_idx[gi]),
            .i_free_idx   (lk_free_idx[gi]),
            .i_ptr        (lk_ptr[gi]),
            .i_wr_en      (wr_en),
            .i_wr_idx     (wr_idx),
            .i_wr_addr    (lk_addr[CACHE_ENTRIES]),
            .i_ptr_wr_en  (ptr_wr_en),
            .i_ptr_wr_set (lk_set[CACHE_ENTRIES]),
            .i_ptr_wr_val (ptr_wr_val),
            .o_flags      (lk_flags[gi+1]),
            .o_addr       (lk_addr[gi+1]),
            .o_base       (lk_base[gi+1]),
            .o_limit      (lk_limit[gi+1]),
            .o_set        (lk_set[gi+1]),
            .o_hit_idx    (lk_hit_idx[gi+1]),
            .o_free_idx   (lk_free_idx[gi+1]),
            .o_ptr        (lk_ptr[gi+1])
        );
    end

    // ------------------------------------------------------------------
    // Resolution at the tail of the chain. A hit reports the matching way.
    // A miss fills the first free way, or else replaces the way named by
    // the set's FIFO pointer and advances that pointer, wrapping at the
    // way count. The cells are updated on the same edge.
    // ------------------------------------------------------------------
    t_probe_flags      tail;
    logic [CNT_W-1:0]  ptr_cur;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  victim;
    logic [IDX_W-1:0]  chosen;
    logic              res_miss;

    assign tail      = lk_flags[CACHE_ENTRIES];
    assign tail_done = tail.active;

    always_comb begin
        ptr_cur = CNT_W'(lk_ptr[CACHE_ENTRIES]);
        if (ptr_cur >= ways) begin
            ptr_cur = '0;
        end
        ptr_inc = ptr_cur + CNT_W'(1);
        victim  = lk_base[CACHE_ENTRIES] + ptr_cur;
        if (tail.hit) begin
            chosen = lk_hit_idx[CACHE_ENTRIES];
        end else if (tail.free) begin
            chosen = lk_free_idx[CACHE_ENTRIES];
        end else begin
            chosen = victim[IDX_W-1:0];
        end
        res_miss   = !tail.hit;
        wr_en      = tail_done && !tail.hit;
        wr_idx     = chosen;
        ptr_wr_en  = tail_done && !tail.hit && !tail.free;
        ptr_wr_val = (ptr_inc >= ways) ? '0 : ptr_inc[IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // Output register plus one pending slot, so a result that arrives
    // while the output is stalled is kept; new items wait while it is full.
    // ------------------------------------------------------------------
    logic              r_out_valid;
    logic              r_out_miss;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_pend_miss;
    logic [SLOT_W-1:0] r_pend_slot;
    logic              out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (tail_done) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_pend_valid <= 1'b1;
            end
        end else if (r_pend_valid && out_free) begin
            r_out_valid  <= 1'b1;
            r_pend_valid <= 1'b0;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_done) begin
            if (out_free) begin
                r_out_miss <= res_miss;
                r_out_slot <= SLOT_W'(chosen);
            end else begin
                r_pend_miss <= res_miss;
                r_pend_slot <= SLOT_W'(chosen);
            end
        end else if (r_pend_valid && out_free) begin
            r_out_miss <= r_pend_miss;
            r_out_slot <= r_pend_slot;
        end
    end

    assign o_valid = r_out_valid;
    assign o_miss  = r_out_miss;
    assign o_slot  = r_out_slot;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    logic [CACHE_ENTRIES:0] probe_act;

    for (genvar ga = 0; ga <= CACHE_ENTRIES; ga++) begin : g_act
        assign probe_act[ga] = lk_flags[ga].active;
    end

    // Only one item is ever inside the chain.
    a_single_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(probe_act))
        else $error("more than one item in the cell chain");

    // The tail only fires while the controller waits for it.
    a_tail_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_done |-> (r_state == ST_SEARCH))
        else $error("item left the chain outside the search state");

    // The pending slot is only used behind a full output register.
    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_out_valid)
        else $error("pending result without an output result");

    // A new result shows up only after a resolution or a pending transfer.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(tail_done) || $past(r_pend_valid)))
        else $error("result appeared without a source");

endmodule

/* rtl/sacfl_cell.sv */
module sacfl_cell import sacfl_pkg::*; #(
    parameter int CACHE_ENTRIES = DEF_CACHE_ENTRIES,
    parameter int CELL_INDEX    = 0,
    parameter int IDX_W         = $clog2(CACHE_ENTRIES),
    parameter int CNT_W         = $clog2(CACHE_ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_flush,
    // Probe coming from the previous cell.
    input  t_probe_flags        i_flags,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [CNT_W-1:0]    i_base,
    input  logic [CNT_W-1:0]    i_limit,
    input  logic [IDX_W-1:0]    i_set,
    input  logic [IDX_W-1:0]    i_hit_idx,
    input  logic [IDX_W-1:0]    i_free_idx,
    input  logic [IDX_W-1:0]    i_ptr,
    // Update broadcast from the controller.
    input  logic                i_wr_en,
    input  logic [IDX_W-1:0]    i_wr_idx,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic                i_ptr_wr_en,
    input  logic [IDX_W-1:0]    i_ptr_wr_set,
    input  logic [IDX_W-1:0]    i_ptr_wr_val,
    // Probe handed to the next cell.
    output t_probe_flags        o_flags,
    output logic [ADDR_W-1:0]   o_addr,
    output logic [CNT_W-1:0]    o_base,
    output logic [CNT_W-1:0]    o_limit,
    output logic [IDX_W-1:0]    o_set,
    output logic [IDX_W-1:0]    o_hit_idx,
    output logic [IDX_W-1:0]    o_free_idx,
    output logic [IDX_W-1:0]    o_ptr
);

    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic [ADDR_W-1:0] r_tag;
    logic              r_valid;
    logic [IDX_W-1:0]  r_ptr;

    t_probe_flags      r_flags, n_flags;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_base;
    logic [CNT_W-1:0]  r_limit;
    logic [IDX_W-1:0]  r_set;
    logic [IDX_W-1:0]  r_hit_idx, n_hit_idx;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [IDX_W-1:0]  r_ptr_out, n_ptr_out;

    logic in_set;

    always_comb begin
        in_set     = (MY_CNT >= i_base) && (MY_CNT < i_limit);
        n_flags    = i_flags;
        n_hit_idx  = i_hit_idx;
        n_free_idx = i_free_idx;
        n_ptr_out  = (i_set == MY_IDX) ? r_ptr : i_ptr;
        // Cells are visited in ascending order, so the first match wins.
        if (i_flags.active && in_set && !i_flags.hit && r_valid && (r_tag == i_addr)) begin
            n_flags.hit = 1'b1;
            n_hit_idx   = MY_IDX;
        end
        if (i_flags.active && in_set && !i_flags.free && !r_valid) begin
            n_flags.free = 1'b1;
            n_free_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
        end else begin
            if (i_wr_en && (i_wr_idx == MY_IDX)) begin
                r_valid <= 1'b1;
            end
            if (i_ptr_wr_en && (i_ptr_wr_set == MY_IDX)) begin
                r_ptr <= i_ptr_wr_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_tag <= i_wr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= i_addr;
        r_base     <= i_base;
        r_limit    <= i_limit;
        r_set      <= i_set;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_ptr_out  <= n_ptr_out;
    end

    assign o_flags    = r_flags;
    assign o_addr     = r_addr;
    assign o_base     = r_base;
    assign o_limit    = r_limit;
    assign o_set      = r_set;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;
    assign o_ptr      = r_ptr_out;

endmodule

/* sim/set_assoc_cache_fifo_lookup_tb.sv */
`timescale 1ns / 100ps

module set_assoc_cache_fifo_lookup_tb;
    import sacfl_pkg::*;

    localparam int CACHE_ENTRIES  = DEF_CACHE_ENTRIES;
    // Register index width on the configuration port (byte address = 4 * index).
    localparam int REG_INDEX_W    = APB_ADDR_W - 2;
    // The only index past the mapped register; writes to it must be ignored.
    localparam logic [REG_INDEX_W-1:0] REG_UNMAPPED = REG_INDEX_W'(REG_SET_COUNT_LOG2) + 1'b1;
    // Random filler in the upper bits of a register write, above a zero bit over the set count field.
    localparam int CFG_PAD_W      = APB_DATA_W - LG_W - 1;
    // Settling time, longer than the block takes to answer a lookup; the bench waits this long
    // once the last result is in before touching the configuration or ending the run.
    localparam int DRAIN_CYCLES   = CACHE_ENTRIES + 8;
    // Length of the one long receiver hold-off that forces the input to back up.
    localparam int LONG_HOLD      = 400;
    // No legal run goes this long without an item moving on either channel.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic              miss;
        logic [SLOT_W-1:0] slot;
    } t_lookup_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_SPARSE
    } t_stall_mode;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [ADDR_W-1:0]     i_block_address = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_miss;
    logic [SLOT_W-1:0]     o_slot;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    set_assoc_cache_fifo_lookup #(
        .CACHE_ENTRIES(CACHE_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_block_address(i_block_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_miss         (o_miss),
        .o_slot         (o_slot),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the cache: tags, valid bits, per-set FIFO pointers and the
    // set count register. It moves only when an item is accepted or when the
    // register is written.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] line_tag   [CACHE_ENTRIES];
    bit                line_valid [CACHE_ENTRIES];
    int                fifo_next  [CACHE_ENTRIES];
    logic [LG_W-1:0]   cfg_set_count_log2 = '0;

    t_lookup_result    expected_lookups[$];
    logic [ADDR_W-1:0] pending_addrs[$];

    int items_queued = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int predicted_hits = 0;
    int predicted_misses = 0;
    int settings_applied = 0;
    int error_count = 0;
    int hold_requests = 0;
    int hold_served = 0;

    function automatic void flush_lines();
        for (int e = 0; e < CACHE_ENTRIES; e++) begin
            line_tag[e]   = '0;
            line_valid[e] = 1'b0;
            fifo_next[e]  = 0;
        end
    endfunction

    // Look up one address in the shadow cache, update it the way the block
    // must, and queue the result the block owes for this item.
    function automatic void predict_lookup(input logic [ADDR_W-1:0] addr);
        int             lg;
        int             sets;
        int             ways;
        int             set_idx;
        int             base;
        int             chosen;
        bit             found;
        t_lookup_result res;
        lg = int'(cfg_set_count_log2);
        // A set count beyond the entry count saturates to direct mapping.
        while (lg > 0 && (1 << lg) > CACHE_ENTRIES)
            lg--;
        sets = 1 << lg;
        ways = CACHE_ENTRIES / sets;
        if (ways == 0)
            ways = 1;
        set_idx = int'(addr & ADDR_W'(sets - 1));
        base = set_idx * ways;
        chosen = 0;
        found = 1'b0;
        // Hit search: the lowest matching valid way wins.
        for (int w = 0; w < ways && !found; w++) begin
            if (base + w < CACHE_ENTRIES && line_valid[base + w] && line_tag[base + w] == addr) begin
                chosen = base + w;
                found = 1'b1;
            end
        end
        if (found) begin
            res.miss = 1'b0;
            predicted_hits++;
        end else begin
            // Miss: fill the lowest free way, else replace in FIFO order.
            for (int w = 0; w < ways && !found; w++) begin
                if (base + w < CACHE_ENTRIES && !line_valid[base + w]) begin
                    chosen = base + w;
                    found = 1'b1;
                end
            end
            if (!found && set_idx < CACHE_ENTRIES) begin
                if (fifo_next[set_idx] >= ways)
                    fifo_next[set_idx] = 0;
                chosen = base + fifo_next[set_idx];
                fifo_next[set_idx] = (fifo_next[set_idx] + 1 >= ways) ? 0 : fifo_next[set_idx] + 1;
                found = 1'b1;
            end
            if (found && chosen < CACHE_ENTRIES) begin
                line_tag[chosen]   = addr;
                line_valid[chosen] = 1'b1;
            end
            res.miss = 1'b1;
            predicted_misses++;
        end
        res.slot = SLOT_W'(chosen);
        expected_lookups.push_back(res);
    endfunction

    function automatic void note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] FAILURE: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------
    // Driver. It presents items from pending_addrs in bursts of random
    // length separated by random gaps. A stalled item is held unchanged, and
    // the next decision is only taken once the current item has been taken.
    // The shadow cache is updated at the edge where the item is accepted.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_lookup(i_block_address);
                items_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_addrs.size() > 0) begin
                    i_block_address <= pending_addrs.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        // About a quarter of the bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Its stall follows a randomly chosen mode that is held for a
    // random stretch: never, coin toss, a periodic pattern or rare single cycles.
    // On request it stalls for the LONG_HOLD hold-off so the block backs up.
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          stall_period = 2;
    int          hold_left = 0;
    int          stall_cycle = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
                stall_period = $urandom_range(2, 7);
            end else begin
                mode_left--;
            end
            stall_cycle++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    STALL_NONE:     i_stall <= 1'b0;
                    STALL_COIN:     i_stall <= $urandom_range(0, 1) == 1;
                    STALL_PERIODIC: i_stall <= (stall_cycle % stall_period) != 0;
                    default:        i_stall <= $urandom_range(0, 7) == 0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result is checked against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_lookups.size() == 0) begin
                note_failure($sformatf("result miss=%0b slot=%0d with nothing expected",
                                       o_miss, o_slot));
            end else begin
                want = expected_lookups.pop_front();
                if (o_miss !== want.miss || o_slot !== want.slot)
                    note_failure($sformatf("result %0d: expected miss=%0b slot=%0d, got miss=%0b slot=%0d",
                                           results_seen, want.miss, want.slot, o_miss, o_slot));
            end
        end
    end

    // Watchdog: counts cycles in which no item moves on either channel.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: %0d cycles without progress, %0d results outstanding",
                     idle_cycles, expected_lookups.size());
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [ADDR_W-1:0] addr);
        pending_addrs.push_back(addr);
        items_queued++;
    endtask

    // Block until every queued item has been accepted and answered, then let
    // the block settle for the drain time.
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_lookups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random lookups that mostly revisit a small working set, so hits, fills
    // and FIFO evictions all happen often. The working set is spread over
    // only a few low-order set indexes; its size ranges from well inside
    // the cache to beyond it so that eviction order matters.
    task automatic queue_random_items(input int count);
        logic [ADDR_W-1:0] pool[$];
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] last_addr;
        int                pool_size;
        int                pick;
        pool_size = $urandom_range(2, 24);
        for (int k = 0; k < pool_size; k++) begin
            addr = $urandom();
            if ($urandom_range(0, 3) != 0)
                addr[3:0] = 4'($urandom_range(0, 3));
            pool.push_back(addr);
        end
        last_addr = pool[0];
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                addr = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 85)
                addr = last_addr;
            else if (pick < 90)
                addr = ($urandom_range(0, 1) == 1) ? '1 : '0;
            else
                addr = $urandom();
            last_addr = addr;
            queue_item(addr);
        end
    endtask

    // Write one register once the block is idle, track it in the shadow and
    // read the set count back.
    task automatic set_register(input logic [REG_INDEX_W-1:0] index,
                                input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] readback;
        wait_idle();
        // Write: setup cycle, then access cycle until pready.
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({index, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The set count register flushes the cache; any other index is ignored.
        if (index == REG_SET_COUNT_LOG2) begin
            cfg_set_count_log2 = data[LG_W-1:0];
            flush_lines();
            settings_applied++;
        end
        // Read the set count back.
        @(posedge i_clk);
        psel    <= 1'b1;
        paddr   <= APB_ADDR_W'({REG_INDEX_W'(REG_SET_COUNT_LOG2), 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[LG_W-1:0] !== cfg_set_count_log2)
            note_failure($sformatf("set_count_log2 read back as %0d, expected %0d",
                                   readback[LG_W-1:0], cfg_set_count_log2));
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    logic [LG_W-1:0] set_counts[8] = '{3'd4, 3'd7, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6, 3'd0};

    initial begin
        flush_lines();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset setting (fully associative, 16 ways):
        // both address extremes miss and then hit, the rest of the ways fill
        // up, and two more misses evict the two oldest entries in FIFO order.
        queue_item('0);
        queue_item('1);
        queue_item('0);
        queue_item('1);
        for (int k = 1; k <= CACHE_ENTRIES - 2; k++)
            queue_item(ADDR_W'(k));
        queue_item(32'h8000_0000);
        queue_item('0);
        queue_random_items(47);
        // Sender pauses here until every result has come back.
        wait_idle();
        queue_random_items(47);

        for (int p = 0; p < 8; p++) begin
            set_register(REG_SET_COUNT_LOG2,
                         {CFG_PAD_W'($urandom_range(0, (1 << CFG_PAD_W) - 1)), 1'b0, set_counts[p]}
                         | ($urandom_range(0, 1) << (APB_DATA_W - 1)));
            if (p == 0) begin
                // Direct mapped: two addresses in the same set push each other out.
                queue_item(32'h0000_0010);
                queue_item(32'h0000_0020);
                queue_item(32'h0000_0010);
            end
            if (p == 1) begin
                // Hold the receiver off for a long stretch while items keep coming.
                hold_requests++;
            end
            queue_random_items(47);
            if (p == 3) begin
                // A write to the unmapped index must leave the cache contents alone.
                set_register(REG_UNMAPPED, $urandom());
            end else begin
                wait_idle();
            end
            queue_random_items(47);
        end

        wait_idle();
        $display("Covered %0d lookups (%0d hits, %0d misses) over %0d set count settings.",
                 items_accepted, predicted_hits, predicted_misses, settings_applied + 1);
        $display("Results checked: %0d, failures: %0d.", results_seen, error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sacfl_pkg.sv
rtl/sacfl_cell.sv
rtl/set_assoc_cache_fifo_lookup.sv
sim/set_assoc_cache_fifo_lookup_tb.sv
